@@ hdl/chained_free_block_allocator_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Chained free block allocator assertion macros
// Shared assertion forms for the allocator checker, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHAINED_FREE_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define CHAINED_FREE_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFBA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cfba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained free block allocator package
// Field widths, status and action codes, payload types and sequencer states.
// ----------------------------------------------------------------------------
package cfba_pkg;

    localparam int BLK_W  = 10;
    localparam int FS_W   = 11;
    localparam int STAT_W = 2;

    // Block numbers are 10 bits wide, so no more spill slots are reachable.
    localparam int BLOCK_LIMIT = 1 << BLK_W;

    localparam logic [FS_W-1:0] FS_SIZE_RESET = 11'd1024;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic             action;
        logic [BLK_W-1:0] block_id;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BLK_W-1:0]  granted_block;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SPILL,
        S_RELOAD,
        S_HOLD
    } state_t;

endpackage

@@ hdl/chained_free_block_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained free block allocator
// Hands out and takes back block numbers kept in a chained free list.
// ----------------------------------------------------------------------------
// Each request is a transfer on the input channel and yields exactly one
// result transfer. An ordinary allocate or release is worked in the execute
// state and its result goes into the output register, and the next request
// is taken once the sequencer is back in idle. A release into a full cache,
// or an allocation of the link block, copies the whole cache to or from the
// block's spill slot one entry per cycle through the shared spill RAM
// address, and no new request is taken until its result is registered. A
// finished result that finds the output register still occupied holds the
// sequencer until that register frees up. The spill store needs no clearing
// after reset, since a slot is only read after it was written; fs_size may
// be written whenever no request is open.
module chained_free_block_allocator_unit #(
    parameter int CACHE_DEPTH = 100,
    parameter int NUM_BLOCKS  = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [cfba_pkg::FS_W-1:0]     cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cfba_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cfba_pkg::out_item_t           out_data
);

    localparam int CIW        = $clog2(CACHE_DEPTH);
    localparam int SPILL_BLKS = (NUM_BLOCKS < cfba_pkg::BLOCK_LIMIT) ?
                                NUM_BLOCKS : cfba_pkg::BLOCK_LIMIT;
    localparam int SPILL_DEPTH = SPILL_BLKS * CACHE_DEPTH;
    localparam int SAW        = $clog2(SPILL_DEPTH);

    logic [cfba_pkg::FS_W-1:0]  fs_size_reg;

    logic                       cache_we;
    logic [CIW-1:0]             cache_waddr;
    logic [cfba_pkg::BLK_W-1:0] cache_wdata;
    logic                       cache_re;
    logic [CIW-1:0]             cache_raddr;
    logic [cfba_pkg::BLK_W-1:0] cache_rdata;
    logic                       spill_we;
    logic                       spill_re;
    logic [SAW-1:0]             spill_addr;
    logic [cfba_pkg::BLK_W-1:0] spill_wdata;
    logic [cfba_pkg::BLK_W-1:0] spill_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_size_reg <= cfba_pkg::FS_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            fs_size_reg <= cfg_wr_data;
        end
    end

    cfba_ctrl #(
        .CACHE_DEPTH (CACHE_DEPTH),
        .NUM_BLOCKS  (NUM_BLOCKS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .fs_size     (fs_size_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cache_we    (cache_we),
        .cache_waddr (cache_waddr),
        .cache_wdata (cache_wdata),
        .cache_re    (cache_re),
        .cache_raddr (cache_raddr),
        .cache_rdata (cache_rdata),
        .spill_we    (spill_we),
        .spill_re    (spill_re),
        .spill_addr  (spill_addr),
        .spill_wdata (spill_wdata),
        .spill_rdata (spill_rdata)
    );

    cfba_ram #(
        .DEPTH (CACHE_DEPTH),
        .WIDTH (cfba_pkg::BLK_W)
    ) u_cache_ram (
        .clk   (clk),
        .we    (cache_we),
        .waddr (cache_waddr),
        .wdata (cache_wdata),
        .re    (cache_re),
        .raddr (cache_raddr),
        .rdata (cache_rdata)
    );

    cfba_ram #(
        .DEPTH (SPILL_DEPTH),
        .WIDTH (cfba_pkg::BLK_W)
    ) u_spill_ram (
        .clk   (clk),
        .we    (spill_we),
        .waddr (spill_addr),
        .wdata (spill_wdata),
        .re    (spill_re),
        .raddr (spill_addr),
        .rdata (spill_rdata)
    );

endmodule

@@ hdl/cfba_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator RAM
// Simple dual-port memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module cfba_ram #(
    parameter int DEPTH = 100,
    parameter int WIDTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/cfba_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator sequencer
// Runs one request at a time, drives both RAMs and copies the cache to or
// from a spill slot one entry per cycle through a shared address adder.
// ----------------------------------------------------------------------------
module cfba_ctrl #(
    parameter int CACHE_DEPTH = 100,
    parameter int NUM_BLOCKS  = 1024,
    localparam int CW          = $clog2(CACHE_DEPTH + 1),
    localparam int CIW         = $clog2(CACHE_DEPTH),
    localparam int SPILL_BLKS  = (NUM_BLOCKS < cfba_pkg::BLOCK_LIMIT) ?
                                 NUM_BLOCKS : cfba_pkg::BLOCK_LIMIT,
    localparam int SAW         = $clog2(SPILL_BLKS * CACHE_DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cfba_pkg::FS_W-1:0]     fs_size,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cfba_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cfba_pkg::out_item_t           out_data,
    // cache RAM, entries 1 and up (entry 0 is the link register)
    output logic                          cache_we,
    output logic [CIW-1:0]                cache_waddr,
    output logic [cfba_pkg::BLK_W-1:0]    cache_wdata,
    output logic                          cache_re,
    output logic [CIW-1:0]                cache_raddr,
    input  logic [cfba_pkg::BLK_W-1:0]    cache_rdata,
    // spill RAM
    output logic                          spill_we,
    output logic                          spill_re,
    output logic [SAW-1:0]                spill_addr,
    output logic [cfba_pkg::BLK_W-1:0]    spill_wdata,
    input  logic [cfba_pkg::BLK_W-1:0]    spill_rdata
);

    localparam logic [CW-1:0] DEPTH_C = CW'(CACHE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    cfba_pkg::state_t             state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [cfba_pkg::BLK_W-1:0]   link_reg, link_next;
    logic                         act_reg, act_next;
    logic [cfba_pkg::BLK_W-1:0]   blk_reg, blk_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic [SAW-1:0]               base_reg, base_next;
    cfba_pkg::out_item_t          pend_reg, pend_next;
    logic                         out_valid_reg, out_valid_next;
    cfba_pkg::out_item_t          out_data_reg, out_data_next;

    logic [CW-1:0]                off;
    logic [SAW-1:0]               addr_sum;
    logic [cfba_pkg::BLK_W-1:0]   top_val;
    logic                         range_bad;
    logic                         fin;
    cfba_pkg::out_item_t          res;

    // Shared address unit: spill slot base plus the entry offset. During a
    // spill each write trails its cache read, landing in the cycle after it.
    always_comb
    begin
        off      = (state_reg == cfba_pkg::S_SPILL) ? (idx_reg - ONE_C) : idx_reg;
        addr_sum = base_reg + SAW'(off);
    end

    assign spill_addr = addr_sum;
    assign top_val    = (count_reg == ONE_C) ? link_reg : cache_rdata;
    assign range_bad  = ({1'b0, blk_reg} >= fs_size) || (32'(blk_reg) >= NUM_BLOCKS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfba_pkg::S_IDLE;
            count_reg     <= ONE_C;
            link_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            link_reg      <= link_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        blk_reg      <= blk_next;
        idx_reg      <= idx_next;
        base_reg     <= base_next;
        pend_reg     <= pend_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        link_next      = link_reg;
        act_next       = act_reg;
        blk_next       = blk_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        in_ready       = 1'b0;
        fin            = 1'b0;
        res            = '0;
        cache_we       = 1'b0;
        cache_waddr    = CIW'(count_reg);
        cache_wdata    = blk_reg;
        cache_re       = 1'b0;
        cache_raddr    = CIW'(idx_reg);
        spill_we       = 1'b0;
        spill_re       = 1'b0;
        spill_wdata    = (idx_reg == ONE_C) ? link_reg : cache_rdata;

        case (state_reg)
            cfba_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                // Fetch the top entry ahead of an allocation.
                cache_raddr = CIW'(count_reg - ONE_C);
                cache_re    = (count_reg != '0) && (count_reg <= DEPTH_C);
                if (in_valid)
                begin
                    act_next   = in_data.action;
                    blk_next   = in_data.block_id;
                    state_next = cfba_pkg::S_EXEC;
                end
            end

            cfba_pkg::S_EXEC:
            begin
                if (act_reg == cfba_pkg::ACT_RELEASE)
                begin
                    if (range_bad)
                    begin
                        res.status = cfba_pkg::STATUS_RANGE;
                        fin        = 1'b1;
                    end
                    else if (count_reg >= DEPTH_C)
                    begin
                        idx_next   = '0;
                        base_next  = SAW'(32'(blk_reg) * CACHE_DEPTH);
                        state_next = cfba_pkg::S_SPILL;
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            link_next = blk_reg;
                        end
                        else
                        begin
                            cache_we = 1'b1;
                        end
                        count_next = count_reg + ONE_C;
                        res.status = cfba_pkg::STATUS_OK;
                        fin        = 1'b1;
                    end
                end
                else
                begin
                    if ((count_reg == '0) || (count_reg > DEPTH_C) || (top_val == '0))
                    begin
                        res.status = cfba_pkg::STATUS_EMPTY;
                        fin        = 1'b1;
                    end
                    else if (count_reg == ONE_C)
                    begin
                        // The link block is handed out and, if it has a spill slot, its slot refills the cache.
                        if (32'(top_val) >= NUM_BLOCKS)
                        begin
                            count_next        = '0;
                            res.status        = cfba_pkg::STATUS_OK;
                            res.granted_block = top_val;
                            fin               = 1'b1;
                        end
                        else
                        begin
                            idx_next                = '0;
                            base_next               = SAW'(32'(top_val) * CACHE_DEPTH);
                            pend_next.status        = cfba_pkg::STATUS_OK;
                            pend_next.granted_block = top_val;
                            state_next              = cfba_pkg::S_RELOAD;
                        end
                    end
                    else
                    begin
                        count_next        = count_reg - ONE_C;
                        res.status        = cfba_pkg::STATUS_OK;
                        res.granted_block = top_val;
                        fin               = 1'b1;
                    end
                end
            end

            cfba_pkg::S_SPILL:
            begin
                cache_raddr = CIW'(idx_reg);
                cache_re    = (idx_reg < DEPTH_C);
                spill_we    = (idx_reg != '0);
                idx_next    = idx_reg + ONE_C;
                if (idx_reg == DEPTH_C)
                begin
                    link_next  = blk_reg;
                    count_next = ONE_C;
                    res.status = cfba_pkg::STATUS_OK;
                    fin        = 1'b1;
                end
            end

            cfba_pkg::S_RELOAD:
            begin
                spill_re    = (idx_reg < DEPTH_C);
                cache_waddr = CIW'(idx_reg - ONE_C);
                cache_wdata = spill_rdata;
                if (idx_reg == ONE_C)
                begin
                    link_next = spill_rdata;
                end
                else if (idx_reg != '0)
                begin
                    cache_we = 1'b1;
                end
                idx_next = idx_reg + ONE_C;
                if (idx_reg == DEPTH_C)
                begin
                    count_next = DEPTH_C;
                    res        = pend_reg;
                    fin        = 1'b1;
                end
            end

            cfba_pkg::S_HOLD:
            begin
                res = pend_reg;
                fin = 1'b1;
            end

            default:
            begin
                state_next = cfba_pkg::S_IDLE;
            end
        endcase

        // A finished result goes to the output register once it is free.
        if (fin)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
                state_next     = cfba_pkg::S_IDLE;
            end
            else
            begin
                pend_next  = res;
                state_next = cfba_pkg::S_HOLD;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hdl/cfba_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the top-level ports of the allocator and is bound to it.
// ----------------------------------------------------------------------------
`include "chained_free_block_allocator_unit_defines.svh"

module cfba_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input cfba_pkg::in_item_t        in_data,
    input logic                      out_valid,
    input logic                      out_ready,
    input cfba_pkg::out_item_t       out_data
);

    logic in_xfer;
    logic out_stall;
    logic out_fail;

    assign in_xfer   = in_valid && in_ready && (in_data.action == in_data.action);
    assign out_stall = out_valid && !out_ready;
    assign out_fail  = out_valid && (out_data.status != cfba_pkg::STATUS_OK);

    // A stalled result must hold its value.
    `CFBA_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "stalled result changed")

    // Requests are worked one at a time, so a transfer always drops ready.
    `CFBA_ASSERT_NEXT(a_one_open, in_xfer, !in_ready, "second request taken while one is open")

    // Only a successful allocation carries a block number.
    `CFBA_ASSERT_SAME(a_grant_zero, out_fail, out_data.granted_block == '0, "block on a failure")

endmodule

bind chained_free_block_allocator_unit cfba_checker u_checker (.*);

@@ verif/chained_free_block_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained free block allocator testbench
// Sends allocate and release requests over the valid/ready channels and keeps
// a shadow copy of the free-block cache, spill store and fs_size. Each result
// transfer is checked in order against a typed row's want or the shadow copy.
// Directed rows go first, then fill and drain phases force spills and reloads.
// ----------------------------------------------------------------------------
module chained_free_block_allocator_unit_tb;

    localparam int CACHE_DEPTH      = 100;
    localparam int NUM_BLOCKS       = 1024;
    localparam int NUM_PHASES       = 12;
    localparam int PHASE_ITEMS      = 150;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int DIRECTED_ROWS    = 24;
    localparam int BLK_W            = cfba_pkg::BLK_W;
    localparam int FS_W             = cfba_pkg::FS_W;
    localparam int STAT_W           = cfba_pkg::STAT_W;

    typedef enum logic [1:0] {
        ROW_ALLOC,
        ROW_RELEASE,
        ROW_SET_FS
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [FS_W-1:0]   arg;
        logic              typed;
        logic [STAT_W-1:0] want_status;
        logic [BLK_W-1:0]  want_block;
    } stim_row_t;

    localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{ROW_ALLOC,   11'd0,    1'b1, cfba_pkg::STATUS_EMPTY, 10'd0},
        '{ROW_RELEASE, 11'd0,    1'b1, cfba_pkg::STATUS_OK,    10'd0},
        '{ROW_ALLOC,   11'd0,    1'b1, cfba_pkg::STATUS_EMPTY, 10'd0},
        '{ROW_RELEASE, 11'd1023, 1'b1, cfba_pkg::STATUS_OK,    10'd0},
        '{ROW_ALLOC,   11'd0,    1'b1, cfba_pkg::STATUS_OK,    10'd1023},
        '{ROW_RELEASE, 11'd512,  1'b1, cfba_pkg::STATUS_OK,    10'd0},
        '{ROW_RELEASE, 11'd341,  1'b1, cfba_pkg::STATUS_OK,    10'd0},
        '{ROW_ALLOC,   11'd0,    1'b1, cfba_pkg::STATUS_OK,    10'd341},
        '{ROW_ALLOC,   11'd0,    1'b1, cfba_pkg::STATUS_OK,    10'd512},
        '{ROW_ALLOC,   11'd0,    1'b1, cfba_pkg::STATUS_EMPTY, 10'd0},
        '{ROW_SET_FS,  11'd1,    1'b0, cfba_pkg::STATUS_OK,    10'd0},
        '{ROW_RELEASE, 11'd1,    1'b1, cfba_pkg::STATUS_RANGE, 10'd0},
        '{ROW_RELEASE, 11'd1023, 1'b1, cfba_pkg::STATUS_RANGE, 10'd0},
        '{ROW_RELEASE, 11'd0,    1'b1, cfba_pkg::STATUS_OK,    10'd0},
        '{ROW_ALLOC,   11'd0,    1'b1, cfba_pkg::STATUS_EMPTY, 10'd0},
        '{ROW_SET_FS,  11'd1023, 1'b0, cfba_pkg::STATUS_OK,    10'd0},
        '{ROW_RELEASE, 11'd1023, 1'b1, cfba_pkg::STATUS_RANGE, 10'd0},
        '{ROW_RELEASE, 11'd1022, 1'b1, cfba_pkg::STATUS_OK,    10'd0},
        '{ROW_RELEASE, 11'd682,  1'b0, cfba_pkg::STATUS_OK,    10'd0},
        '{ROW_ALLOC,   11'd0,    1'b0, cfba_pkg::STATUS_OK,    10'd0},
        '{ROW_ALLOC,   11'd0,    1'b1, cfba_pkg::STATUS_OK,    10'd1022},
        '{ROW_SET_FS,  11'd1024, 1'b0, cfba_pkg::STATUS_OK,    10'd0},
        '{ROW_RELEASE, 11'd1023, 1'b1, cfba_pkg::STATUS_OK,    10'd0},
        '{ROW_ALLOC,   11'd0,    1'b1, cfba_pkg::STATUS_OK,    10'd1023}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [FS_W-1:0]      cfg_wr_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    cfba_pkg::in_item_t   in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    cfba_pkg::out_item_t  out_data;

    // Shadow copy of the allocator state.
    int                   fs_limit = int'(cfba_pkg::FS_SIZE_RESET);
    int                   free_count = 1;
    logic [BLK_W-1:0]     free_stack [0:CACHE_DEPTH-1];
    int                   spill_len [0:NUM_BLOCKS-1];
    logic [BLK_W-1:0]     spill_mem [0:NUM_BLOCKS*CACHE_DEPTH-1];

    cfba_pkg::out_item_t  pending_grants [$];
    cfba_pkg::out_item_t  grant_want;
    int                   mismatches = 0;
    int                   stall_cycles = 0;
    logic                 sender_gaps = 1'b1;
    logic                 quiet = 1'b0;
    logic                 sink_hold = 1'b0;
    logic                 sink_calm = 1'b0;

    chained_free_block_allocator_unit #(
        .CACHE_DEPTH (CACHE_DEPTH),
        .NUM_BLOCKS  (NUM_BLOCKS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    always #6 clk = ~clk;

    function automatic cfba_pkg::out_item_t predict_grant(input cfba_pkg::in_item_t req);
        cfba_pkg::out_item_t res;
        int                  top;
        int                  n;
        int                  base;
        int                  i;
        logic [BLK_W-1:0]    got;
        res.status        = cfba_pkg::STATUS_OK;
        res.granted_block = '0;
        if (req.action == cfba_pkg::ACT_RELEASE)
        begin
            if (int'(req.block_id) >= fs_limit || int'(req.block_id) >= NUM_BLOCKS)
                res.status = cfba_pkg::STATUS_RANGE;
            else if (free_count >= CACHE_DEPTH)
            begin
                // Full cache: it moves into the released block, which becomes the link.
                base = int'(req.block_id) * CACHE_DEPTH;
                spill_len[req.block_id] = CACHE_DEPTH;
                for (i = 0; i < CACHE_DEPTH; i++)
                    spill_mem[base + i] = free_stack[i];
                free_stack[0] = req.block_id;
                free_count    = 1;
            end
            else
            begin
                free_stack[free_count] = req.block_id;
                free_count++;
            end
        end
        else if (free_count == 0 || free_count > CACHE_DEPTH)
            res.status = cfba_pkg::STATUS_EMPTY;
        else
        begin
            top = free_count - 1;
            got = free_stack[top];
            if (got == '0)
                res.status = cfba_pkg::STATUS_EMPTY;
            else
            begin
                if (top == 0)
                begin
                    // Handing out the link block pulls its saved list back in.
                    n = spill_len[got];
                    if (n > CACHE_DEPTH)
                        n = CACHE_DEPTH;
                    base = int'(got) * CACHE_DEPTH;
                    for (i = 0; i < n; i++)
                        free_stack[i] = spill_mem[base + i];
                    free_count = n;
                end
                else
                    free_count = top;
                res.granted_block = got;
            end
        end
        return res;
    endfunction

    task automatic log_mismatch(input string what, input cfba_pkg::out_item_t want,
                                input cfba_pkg::out_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected status %0d block %0d, got status %0d block %0d",
                     what, want.status, want.granted_block, got.status,
                     got.granted_block);
    endtask

    // Offers one request and records its expected result once the transfer happens.
    task automatic send_item(input cfba_pkg::in_item_t req, input logic typed,
                             input cfba_pkg::out_item_t typed_want);
        cfba_pkg::out_item_t predicted;
        if (sender_gaps && !quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_grant(req);
        pending_grants.push_back(typed ? typed_want : predicted);
    endtask

    // fs_size only changes while no request is open.
    task automatic set_fs_size(input int value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_grants.size() != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[FS_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        fs_limit = value;
    endtask

    // Result side: random short stalls, one long hold on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                sink_calm = !sink_calm;
            if (sink_hold)
            begin
                out_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                sink_hold = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!quiet && !sink_calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_grants.size() == 0)
                log_mismatch("result with nothing expected", '0, out_data);
            else
            begin
                grant_want = pending_grants.pop_front();
                if (out_data.status !== grant_want.status)
                    log_mismatch("status", grant_want, out_data);
                if (out_data.granted_block !== grant_want.granted_block)
                    log_mismatch("granted block", grant_want, out_data);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        cfba_pkg::in_item_t  req;
        cfba_pkg::out_item_t want;
        int                  row;
        int                  phase;
        int                  n;
        int                  r;
        int                  fs_pick;
        int                  release_pct;

        for (n = 0; n < CACHE_DEPTH; n++)
            free_stack[n] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (DIRECTED[row].kind == ROW_SET_FS)
                set_fs_size(int'(DIRECTED[row].arg));
            else
            begin
                req.action   = (DIRECTED[row].kind == ROW_RELEASE) ?
                               cfba_pkg::ACT_RELEASE : cfba_pkg::ACT_ALLOC;
                req.block_id = DIRECTED[row].arg[BLK_W-1:0];
                want.status        = DIRECTED[row].want_status;
                want.granted_block = DIRECTED[row].want_block;
                send_item(req, DIRECTED[row].typed, want);
            end
        end

        // Fill phases push the cache past full so it spills; drain phases walk
        // back down through the chain and reload.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            r = $urandom_range(0, 19);
            if (phase == 0 || r < 12)
                fs_pick = int'(cfba_pkg::FS_SIZE_RESET);
            else if (r < 15)
                fs_pick = int'(cfba_pkg::FS_SIZE_RESET) - 1;
            else if (r < 19)
                fs_pick = $urandom_range(1023, 512);
            else
                fs_pick = $urandom_range(64, 1);
            set_fs_size(fs_pick);
            quiet       = (phase == NUM_PHASES - 1);
            sender_gaps = !quiet && ($urandom_range(0, 3) != 0);
            if (quiet)
                release_pct = 50;
            else if (phase % 6 < 3)
                release_pct = 80;
            else
                release_pct = 20;
            if (phase == 1)
                sink_hold = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                req.action = ($urandom_range(0, 99) < release_pct) ?
                             cfba_pkg::ACT_RELEASE : cfba_pkg::ACT_ALLOC;
                r = $urandom_range(0, 99);
                if (r < 2)
                    req.block_id = '0;
                else if (r < 92 && fs_limit > 1)
                    req.block_id = BLK_W'($urandom_range(fs_limit - 1, 1));
                else
                    req.block_id = BLK_W'($urandom_range(cfba_pkg::BLOCK_LIMIT - 1, 0));
                send_item(req, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (CACHE_DEPTH + 8) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
